[hdl/dsu_pkg.sv]
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants of the union-find unit
// Holds the request opcodes, the queued command format and the result format.
// ----------------------------------------------------------------------------
package dsu_pkg;

	// Fixed field widths of the request and result ports.
	localparam int unsigned IDX_W  = 17;
	localparam int unsigned SIZE_W = 18;

	// Largest set size that the result port can show.
	localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

	// Element count after reset.
	localparam logic [SIZE_W-1:0] COUNT_RESET = 18'd131072;

	// Request opcodes.
	typedef enum logic [1:0] {
		OP_UNITE = 2'd0,
		OP_QUERY = 2'd1,
		OP_FIND  = 2'd2,
		OP_SIZE  = 2'd3
	} op_t;

	// Classified request, passed from the front end to the back end.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             err;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic              status;
		logic              same_set;
		logic              merged;
		logic [IDX_W-1:0]  root_index;
		logic [SIZE_W-1:0] set_size;
	} res_t;

endpackage

[hdl/disjoint_set_union_find_unit.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_find_unit: union-find engine with path compression
// Front end checks and queues requests; back end runs them on the tables.
//
//   channel   handshake             payload
//   request   push / full           opcode, first_index, second_index
//   result    pop / empty           status, same_set, merged, root_index,
//                                   set_size
//   config    cfg_valid / cfg_ready cfg_data (element count)
//
// A rejected request goes from the pop state straight to the emit state. Else
// each find reads and checks one parent per link up to the root, then reads and
// rewrites each compressed link; next comes a size lookup, or for a unite of two
// roots two size reads and a sum that also links them. A result is emitted once
// the result queue has room. After reset the back end clears both tables, one
// entry per cycle, with full held high; two-entry queues let both sides stall.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_unit #(
	parameter int unsigned MAX_ELEMENTS = 131072
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dsu_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  opcode,
	input  logic [dsu_pkg::IDX_W-1:0]   first_index,
	input  logic [dsu_pkg::IDX_W-1:0]   second_index,
	output logic                        empty,
	input  logic                        pop,
	output logic                        status,
	output logic                        same_set,
	output logic                        merged,
	output logic [dsu_pkg::IDX_W-1:0]   root_index,
	output logic [dsu_pkg::SIZE_W-1:0]  set_size
);

	localparam int unsigned CMD_W = $bits(dsu_pkg::cmd_t);
	localparam int unsigned RES_W = $bits(dsu_pkg::res_t);

	logic          clearing;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_pop;
	logic          cmd_empty;
	dsu_pkg::cmd_t cmd_wdata;
	logic [CMD_W-1:0] cmd_rbits;
	logic          res_push;
	logic          res_full;
	dsu_pkg::res_t res_wdata;
	logic [RES_W-1:0] res_rbits;
	dsu_pkg::res_t res_head;

	dsu_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.first_index  (first_index),
		.second_index (second_index),
		.clearing     (clearing),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd_wdata    (cmd_wdata)
	);

	dsu_fifo #(.WIDTH(CMD_W)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wdata   (cmd_wdata),
		.full_o  (cmd_full),
		.rd_en   (cmd_pop),
		.rdata   (cmd_rbits),
		.empty_o (cmd_empty)
	);

	dsu_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_rdata (dsu_pkg::cmd_t'(cmd_rbits)),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_wdata (res_wdata),
		.clearing  (clearing)
	);

	dsu_fifo #(.WIDTH(RES_W)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wdata   (res_wdata),
		.full_o  (res_full),
		.rd_en   (pop),
		.rdata   (res_rbits),
		.empty_o (empty)
	);

	// Oldest result onto the output ports.
	assign res_head   = dsu_pkg::res_t'(res_rbits);
	assign status     = res_head.status;
	assign same_set   = res_head.same_set;
	assign merged     = res_head.merged;
	assign root_index = res_head.root_index;
	assign set_size   = res_head.set_size;

endmodule

[hdl/dsu_fifo.sv]
// ----------------------------------------------------------------------------
// dsu_fifo: two-entry queue
// Decouples a producer and a consumer; push and pop may happen together.
// ----------------------------------------------------------------------------
module dsu_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	output logic             full_o,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             empty_o
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full_o  = (count_q == 2'd2);
	assign empty_o = (count_q == 2'd0);
	assign do_wr   = wr_en && !full_o;
	assign do_rd   = rd_en && !empty_o;
	assign rdata   = slot_q[rptr_q];

	// Storage slots carry no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hdl/dsu_front.sv]
// ----------------------------------------------------------------------------
// dsu_front: request intake and range check
// Holds the element count register, checks indices and queues commands.
// ----------------------------------------------------------------------------
module dsu_front #(
	parameter int unsigned MAX_ELEMENTS = 131072
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dsu_pkg::SIZE_W-1:0] cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 opcode,
	input  logic [dsu_pkg::IDX_W-1:0]  first_index,
	input  logic [dsu_pkg::IDX_W-1:0]  second_index,
	input  logic                       clearing,
	input  logic                       cmd_full,
	output logic                       cmd_push,
	output dsu_pkg::cmd_t              cmd_wdata
);

	logic [dsu_pkg::SIZE_W-1:0] count_q;
	logic                       a_ok;
	logic                       b_ok;
	logic                       needs_b;
	dsu_pkg::op_t               op;

	assign cfg_ready = 1'b1;

	// Element count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= dsu_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// An index must be below both the count and the table depth.
	always_comb begin
		op      = dsu_pkg::op_t'(opcode);
		needs_b = (op == dsu_pkg::OP_UNITE) || (op == dsu_pkg::OP_QUERY);
		a_ok    = (18'(first_index) < count_q) &&
		          (32'(first_index) < 32'(MAX_ELEMENTS));
		b_ok    = (18'(second_index) < count_q) &&
		          (32'(second_index) < 32'(MAX_ELEMENTS));
		cmd_wdata.op  = op;
		cmd_wdata.a   = first_index;
		cmd_wdata.b   = second_index;
		cmd_wdata.err = !a_ok || (needs_b && !b_ok);
	end

	// No request is taken while the tables are being cleared.
	assign full     = cmd_full || clearing;
	assign cmd_push = push && !full;

endmodule

[hdl/dsu_back.sv]
// ----------------------------------------------------------------------------
// dsu_back: union-find execution engine
// Owns the parent and size tables, walks and compresses paths, links roots.
// ----------------------------------------------------------------------------
module dsu_back #(
	parameter int unsigned MAX_ELEMENTS = 131072
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  dsu_pkg::cmd_t cmd_rdata,
	input  logic          res_full,
	output logic          res_push,
	output dsu_pkg::res_t res_wdata,
	output logic          clearing
);

	localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned SW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ELEMENTS - 1);

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_SZ_RD_A,
		ST_SZ_RD_B,
		ST_SZ_SUM,
		ST_SZ_OUT_RD,
		ST_SZ_OUT,
		ST_EMIT
	} state_t;

	state_t        st_q;
	logic [IW-1:0] sweep_q;
	dsu_pkg::cmd_t cmd_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] start_q;
	logic [IW-1:0] root_q;
	logic [IW-1:0] ra_q;
	logic [IW-1:0] rb_q;
	logic          phase_q;
	logic          same_q;
	logic          merged_q;
	logic [SW-1:0] sa_q;
	logic [SW-1:0] sz_q;

	logic [IW-1:0] par_mem [MAX_ELEMENTS];
	logic [SW-1:0] size_mem [MAX_ELEMENTS];
	logic [IW-1:0] par_rd_q;
	logic [SW-1:0] size_rd_q;

	logic          par_we;
	logic [IW-1:0] par_waddr;
	logic [IW-1:0] par_wdata;
	logic          size_we;
	logic [IW-1:0] size_waddr;
	logic [SW-1:0] size_wdata;
	logic [IW-1:0] size_raddr;
	logic [SW-1:0] sum;
	logic          needs_b;

	assign clearing = (st_q == ST_SWEEP);
	assign cmd_pop  = (st_q == ST_IDLE) && !cmd_empty;
	assign res_push = (st_q == ST_EMIT) && !res_full;
	assign sum      = sa_q + size_rd_q;
	assign needs_b  = (cmd_q.op == dsu_pkg::OP_UNITE) || (cmd_q.op == dsu_pkg::OP_QUERY);

	// Table write ports: clearing pass, path compression and linking.
	always_comb begin
		par_we     = 1'b0;
		par_waddr  = cur_q;
		par_wdata  = root_q;
		size_we    = 1'b0;
		size_waddr = rb_q;
		size_wdata = sum;
		size_raddr = (st_q == ST_SZ_RD_B) ? rb_q : ra_q;
		case (st_q)
			ST_SWEEP: begin
				par_we     = 1'b1;
				par_waddr  = sweep_q;
				par_wdata  = sweep_q;
				size_we    = 1'b1;
				size_waddr = sweep_q;
				size_wdata = SW'(1);
			end
			ST_CMP_WR: begin
				par_we = 1'b1;
			end
			ST_SZ_SUM: begin
				par_we    = 1'b1;
				par_waddr = ra_q;
				par_wdata = rb_q;
				size_we   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Parent and size memories with registered reads.
	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= par_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		size_rd_q <= size_mem[size_raddr];
	end

	// Result formatting, with the size saturated to the port width.
	always_comb begin
		res_wdata = '0;
		if (cmd_q.err) begin
			res_wdata.status = 1'b1;
		end else begin
			res_wdata.same_set   = same_q;
			res_wdata.merged     = merged_q;
			res_wdata.root_index = dsu_pkg::IDX_W'(ra_q);
			res_wdata.set_size   = (32'(sz_q) > 32'(dsu_pkg::SIZE_SAT)) ?
			                       dsu_pkg::SIZE_SAT : dsu_pkg::SIZE_W'(sz_q);
		end
	end

	// Sequencer: find with compression, then link and size lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_SWEEP;
			sweep_q  <= '0;
			cmd_q    <= '0;
			cur_q    <= '0;
			start_q  <= '0;
			root_q   <= '0;
			ra_q     <= '0;
			rb_q     <= '0;
			phase_q  <= 1'b0;
			same_q   <= 1'b0;
			merged_q <= 1'b0;
			sa_q     <= '0;
			sz_q     <= '0;
		end else begin
			unique case (st_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + IW'(1);
					if (sweep_q == LAST_IDX) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q    <= cmd_rdata;
						same_q   <= 1'b0;
						merged_q <= 1'b0;
						phase_q  <= 1'b0;
						cur_q    <= IW'(cmd_rdata.a);
						start_q  <= IW'(cmd_rdata.a);
						st_q     <= cmd_rdata.err ? ST_EMIT : ST_WALK_RD;
					end
				end
				ST_WALK_RD: begin
					st_q <= ST_WALK_CHK;
				end
				ST_WALK_CHK: begin
					if (par_rd_q == cur_q) begin
						root_q <= cur_q;
						cur_q  <= start_q;
						st_q   <= ST_CMP_RD;
					end else begin
						cur_q <= par_rd_q;
						st_q  <= ST_WALK_RD;
					end
				end
				ST_CMP_RD: begin
					if (cur_q == root_q) begin
						if (!phase_q) begin
							ra_q <= root_q;
							if (needs_b) begin
								phase_q <= 1'b1;
								cur_q   <= IW'(cmd_q.b);
								start_q <= IW'(cmd_q.b);
								st_q    <= ST_WALK_RD;
							end else begin
								st_q <= ST_SZ_OUT_RD;
							end
						end else begin
							rb_q   <= root_q;
							same_q <= (ra_q == root_q);
							if (cmd_q.op == dsu_pkg::OP_UNITE && ra_q != root_q) begin
								st_q <= ST_SZ_RD_A;
							end else begin
								st_q <= ST_SZ_OUT_RD;
							end
						end
					end else begin
						st_q <= ST_CMP_WR;
					end
				end
				ST_CMP_WR: begin
					cur_q <= par_rd_q;
					st_q  <= ST_CMP_RD;
				end
				ST_SZ_RD_A: begin
					st_q <= ST_SZ_RD_B;
				end
				ST_SZ_RD_B: begin
					sa_q <= size_rd_q;
					st_q <= ST_SZ_SUM;
				end
				ST_SZ_SUM: begin
					sz_q     <= sum;
					ra_q     <= rb_q;
					merged_q <= 1'b1;
					st_q     <= ST_EMIT;
				end
				ST_SZ_OUT_RD: begin
					st_q <= ST_SZ_OUT;
				end
				ST_SZ_OUT: begin
					sz_q <= size_rd_q;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_full) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is only pushed into a queue with room.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// Linking only happens between two distinct roots.
	assert property (@(posedge clk) disable iff (!arst_n) (st_q == ST_SZ_SUM) |-> (ra_q != rb_q))
		else $error("link of a root under itself");

	// A successful result always reports a nonempty set.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !cmd_q.err |-> (sz_q != '0))
		else $error("zero set size reported");

	// Merged implies the elements were in different sets.
	assert property (@(posedge clk) disable iff (!arst_n) res_push && merged_q |-> !same_q)
		else $error("merge reported for one set");

endmodule

[tb/sv/disjoint_set_union_find_unit_tb.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_find_unit_tb: self-checking bench of the union-find unit
// Drives requests through the push/full queue, predicts every result with a
// path-compressing disjoint-set model held here, and checks each popped result
// field by field. The element count is changed between phases while idle.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_unit_tb;

	localparam int unsigned ELEMS = 131072;
	localparam int unsigned WATCHDOG_LIMIT = 600000;

	// Expected result of one request.
	typedef struct {
		logic                       status;
		logic                       same_set;
		logic                       merged;
		logic [dsu_pkg::IDX_W-1:0]  root_index;
		logic [dsu_pkg::SIZE_W-1:0] set_size;
	} outcome_t;

	// Disjoint-set predictor and the queue of pending outcomes.
	class forest_scoreboard;
		logic [dsu_pkg::IDX_W-1:0]  link[ELEMS];
		logic [dsu_pkg::SIZE_W-1:0] weight[ELEMS];
		logic [dsu_pkg::SIZE_W-1:0] count_limit;
		outcome_t                   pending[$];
		int                         errors;

		function void clear_forest();
			for (int i = 0; i < ELEMS; i++) begin
				link[i] = dsu_pkg::IDX_W'(i);
				weight[i] = dsu_pkg::SIZE_W'(1);
			end
			count_limit = dsu_pkg::COUNT_RESET;
			errors = 0;
		endfunction

		// Walks to the root, then points the walked path at it.
		function logic [dsu_pkg::IDX_W-1:0] root_of(logic [dsu_pkg::IDX_W-1:0] x);
			logic [dsu_pkg::IDX_W-1:0] r;
			logic [dsu_pkg::IDX_W-1:0] cur;
			logic [dsu_pkg::IDX_W-1:0] nxt;
			r = x;
			while (link[r] != r) r = link[r];
			cur = x;
			while (cur != r) begin
				nxt = link[cur];
				link[cur] = r;
				cur = nxt;
			end
			return r;
		endfunction

		function void note_request(dsu_pkg::op_t op, logic [dsu_pkg::IDX_W-1:0] a,
				logic [dsu_pkg::IDX_W-1:0] b);
			outcome_t o;
			logic [18:0] lim;
			logic [dsu_pkg::IDX_W-1:0] ra;
			logic [dsu_pkg::IDX_W-1:0] rb;
			logic two;
			o = '{1'b0, 1'b0, 1'b0, '0, '0};
			lim = (count_limit > ELEMS) ? 19'(ELEMS) : 19'(count_limit);
			two = (op == dsu_pkg::OP_UNITE) || (op == dsu_pkg::OP_QUERY);
			if (a >= lim || (two && b >= lim)) begin
				o.status = 1'b1;
			end else begin
				ra = root_of(a);
				if (two) begin
					rb = root_of(b);
					o.same_set = (ra == rb);
					if (op == dsu_pkg::OP_UNITE && ra != rb) begin
						weight[rb] = weight[rb] + weight[ra];
						link[ra] = rb;
						o.merged = 1'b1;
						ra = rb;
					end
				end
				o.root_index = ra;
				o.set_size = weight[ra];
			end
			pending.push_back(o);
		endfunction

		function void check_result(logic st, logic ss, logic mg,
				logic [dsu_pkg::IDX_W-1:0] ri, logic [dsu_pkg::SIZE_W-1:0] sz);
			outcome_t o;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d root=%0d size=%0d",
					$time, st, ri, sz);
				errors++;
				return;
			end
			o = pending.pop_front();
			if (st !== o.status) begin
				$display("%0t: status expected %0d actual %0d", $time, o.status, st);
				errors++;
			end
			if (ss !== o.same_set) begin
				$display("%0t: same_set expected %0d actual %0d", $time, o.same_set, ss);
				errors++;
			end
			if (mg !== o.merged) begin
				$display("%0t: merged expected %0d actual %0d", $time, o.merged, mg);
				errors++;
			end
			if (ri !== o.root_index) begin
				$display("%0t: root_index expected %0d actual %0d",
					$time, o.root_index, ri);
				errors++;
			end
			if (sz !== o.set_size) begin
				$display("%0t: set_size expected %0d actual %0d", $time, o.set_size, sz);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [dsu_pkg::SIZE_W-1:0] cfg_data = '0;
	logic                       push = 1'b0;
	logic                       full;
	logic [1:0]                 opcode = '0;
	logic [dsu_pkg::IDX_W-1:0]  first_index = '0;
	logic [dsu_pkg::IDX_W-1:0]  second_index = '0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic                       status;
	logic                       same_set;
	logic                       merged;
	logic [dsu_pkg::IDX_W-1:0]  root_index;
	logic [dsu_pkg::SIZE_W-1:0] set_size;

	forest_scoreboard board;
	int  idle_cycles = 0;
	bit  hold_off = 1'b0;
	bit  no_stall = 1'b0;
	logic [dsu_pkg::SIZE_W-1:0] span;

	always #5 clk = ~clk;

	disjoint_set_union_find_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.push(push), .full(full), .opcode(opcode),
		.first_index(first_index), .second_index(second_index),
		.empty(empty), .pop(pop), .status(status), .same_set(same_set),
		.merged(merged), .root_index(root_index), .set_size(set_size)
	);

	// Sample accepted transactions on the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				board.note_request(dsu_pkg::op_t'(opcode), first_index, second_index);
			end
			if (pop && !empty) begin
				board.check_result(status, same_set, merged, root_index, set_size);
			end
			if ((push && !full) || (pop && !empty) || (!push && board.pending.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver stall pattern, with an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off) pop <= 1'b0;
		else if (no_stall) pop <= 1'b1;
		else pop <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog on cycles with no progress.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL disjoint_set_union_find_unit");
			$finish;
		end
	end

	task automatic write_count(logic [dsu_pkg::SIZE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.count_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offers one request; push stays high into the next request.
	task automatic send_request(dsu_pkg::op_t op, logic [dsu_pkg::IDX_W-1:0] a,
			logic [dsu_pkg::IDX_W-1:0] b);
		opcode <= op;
		first_index <= a;
		second_index <= b;
		push <= 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic rest(int n);
		push <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Mostly in-range indices within a small pool so that sets grow and merge.
	function automatic logic [dsu_pkg::IDX_W-1:0] pick_index(
			logic [dsu_pkg::SIZE_W-1:0] lim, int pool);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return dsu_pkg::IDX_W'($urandom);
		if (r == 1 && lim > 0)
			return (lim > ELEMS) ? dsu_pkg::IDX_W'(ELEMS - 1) : dsu_pkg::IDX_W'(lim - 1);
		if (lim == 0) return dsu_pkg::IDX_W'($urandom);
		if (lim > ELEMS) lim = dsu_pkg::SIZE_W'(ELEMS);
		return dsu_pkg::IDX_W'($urandom_range(0, ((pool < lim) ? pool : lim) - 1));
	endfunction

	task automatic random_phase(int n, logic [dsu_pkg::SIZE_W-1:0] lim, int pool);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && n > 0) begin
				send_request(dsu_pkg::op_t'($urandom_range(0, 3)),
					pick_index(lim, pool), pick_index(lim, pool));
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0) rest($urandom_range(1, 12));
		end
	endtask

	initial begin
		board = new();
		board.clear_forest();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every opcode, out-of-range cases.
		send_request(dsu_pkg::OP_FIND, 0, 0);
		send_request(dsu_pkg::OP_SIZE, dsu_pkg::IDX_W'(ELEMS - 1), 0);
		send_request(dsu_pkg::OP_UNITE, 0, 1);
		send_request(dsu_pkg::OP_UNITE, 1, 0);
		send_request(dsu_pkg::OP_UNITE, 2, 3);
		send_request(dsu_pkg::OP_UNITE, 3, 1);
		send_request(dsu_pkg::OP_QUERY, 2, 0);
		send_request(dsu_pkg::OP_QUERY, 4, 0);
		send_request(dsu_pkg::OP_FIND, 2, 17'h1FFFF);
		send_request(dsu_pkg::OP_SIZE, 0, 17'h1FFFF);
		send_request(dsu_pkg::OP_UNITE, dsu_pkg::IDX_W'(ELEMS - 1), 0);
		send_request(dsu_pkg::OP_UNITE, 17'h15555, 17'h0AAAA);
		send_request(dsu_pkg::OP_QUERY, 17'h0AAAA, 17'h15555);
		drain();
		write_count(0);
		send_request(dsu_pkg::OP_FIND, 0, 0);
		send_request(dsu_pkg::OP_QUERY, 0, 0);
		drain();
		write_count(18'h3FFFF);
		send_request(dsu_pkg::OP_FIND, 17'h1FFFF, 0);
		send_request(dsu_pkg::OP_SIZE, 17'h15555, 0);
		drain();
		write_count(8);
		send_request(dsu_pkg::OP_FIND, 8, 0);
		send_request(dsu_pkg::OP_QUERY, 3, 9);
		send_request(dsu_pkg::OP_FIND, 2, 0);
		send_request(dsu_pkg::OP_UNITE, 7, 6);
		drain();

		// Random phases over several element counts.
		write_count(1);
		random_phase(80, 1, 4);
		drain();
		write_count(64);
		random_phase(500, 64, 64);
		drain();
		write_count(dsu_pkg::COUNT_RESET);
		random_phase(500, dsu_pkg::COUNT_RESET, 256);
		drain();

		// Long receiver hold-off while requests keep coming.
		hold_off = 1'b1;
		fork
			random_phase(40, dsu_pkg::COUNT_RESET, 256);
			repeat (300) @(negedge clk);
		join_any
		hold_off = 1'b0;
		wait fork;
		drain();

		span = dsu_pkg::SIZE_W'($urandom_range(2, 131071));
		write_count(span);
		no_stall = 1'b1;
		random_phase(200, span, 512);
		no_stall = 1'b0;
		random_phase(380, span, 512);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASS disjoint_set_union_find_unit");
		end else begin
			$display("FAIL disjoint_set_union_find_unit");
		end
		$finish;
	end
endmodule

[filelist.f]
hdl/dsu_pkg.sv
hdl/dsu_fifo.sv
hdl/dsu_front.sv
hdl/dsu_back.sv
hdl/disjoint_set_union_find_unit.sv
tb/sv/disjoint_set_union_find_unit_tb.sv
